@@ rtl/core/qtp_pkg.sv @@
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared types and codes for the transport parameter block parser: result
// record, push bundle between parser and result queue, result kinds and
// parameter codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qtp_pkg;

  // Result kinds
  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_STRB   = 4'd1;
  localparam logic [3:0] KIND_EMPTY  = 4'd2;
  localparam logic [3:0] KIND_FLAG   = 4'd3;
  localparam logic [3:0] KIND_CHOSEN = 4'd4;
  localparam logic [3:0] KIND_AVAIL  = 4'd5;
  localparam logic [3:0] KIND_SKIP   = 4'd6;
  localparam logic [3:0] KIND_DONE   = 4'd7;
  localparam logic [3:0] KIND_ERR    = 4'd8;

  // Parameter codes with special handling
  localparam logic [4:0] PCODE_NONE = 5'd0;
  localparam logic [4:0] PCODE_FLAG = 5'd12;
  localparam logic [4:0] PCODE_VER  = 5'd17;
  localparam logic [4:0] PCODE_UNK  = 5'd18;

  // Byte-string parameter codes
  localparam logic [4:0] PCODE_ORIG_DCID   = 5'd0;
  localparam logic [4:0] PCODE_RESET_TOKEN = 5'd2;
  localparam logic [4:0] PCODE_PREF_ADDR   = 5'd13;
  localparam logic [4:0] PCODE_INIT_SCID   = 5'd15;
  localparam logic [4:0] PCODE_RETRY_SCID  = 5'd16;

  // Version words are four bytes
  localparam int unsigned WORD_BYTES = 4;

  // Result queue depth; one byte pushes at most two results
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  param_code;
    logic [61:0] value;
    logic        last_in_param;
    logic        last_of_run;
  } qtp_result_t;

  // Up to two results from one byte; slot one is used only with slot zero
  typedef struct packed {
    logic        v0;
    logic        v1;
    qtp_result_t r0;
    qtp_result_t r1;
  } qtp_push_t;

endpackage

`default_nettype wire

@@ rtl/core/qtp_parser.sv @@
// ----------------------------------------------------------------------------
// qtp_parser
// Parse state and combinational step logic: consumes one registered byte per
// fire and pushes up to two results to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qtp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              final_byte_i,
  output qtp_pkg::qtp_push_t     push_o
);

  // Phase codes
  localparam logic [2:0] PH_TYPE  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_INTV  = 3'd2;
  localparam logic [2:0] PH_PAD   = 3'd3;
  localparam logic [2:0] PH_STR   = 3'd4;
  localparam logic [2:0] PH_FLAGV = 3'd5;
  localparam logic [2:0] PH_VERC  = 3'd6;
  localparam logic [2:0] PH_VERA  = 3'd7;

  localparam logic [1:0] WordLast = 2'(qtp_pkg::WORD_BYTES - 1);

  function automatic logic is_string(input logic [4:0] p);
    return (p == qtp_pkg::PCODE_ORIG_DCID) || (p == qtp_pkg::PCODE_RESET_TOKEN) ||
           (p == qtp_pkg::PCODE_PREF_ADDR) || (p == qtp_pkg::PCODE_INIT_SCID) ||
           (p == qtp_pkg::PCODE_RETRY_SCID);
  endfunction

  function automatic qtp_pkg::qtp_result_t make_res(input logic [3:0]  kind,
                                                     input logic [4:0]  code,
                                                     input logic [61:0] val,
                                                     input logic        lastp);
    qtp_pkg::qtp_result_t r;
    r.kind          = kind;
    r.param_code    = code;
    r.value         = val;
    r.last_in_param = lastp;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  logic [2:0]  phase_q, phase_d;
  logic [61:0] vacc_q, vacc_d;
  logic [2:0]  vleft_q, vleft_d;
  logic [4:0]  cur_q, cur_d;
  logic [61:0] region_q, region_d;
  logic [31:0] wacc_q, wacc_d;
  logic [1:0]  wbytes_q, wbytes_d;
  logic        failed_q, failed_d;

  // Varint feed of the current byte
  logic [61:0] vf_acc;
  logic [2:0]  vf_left;
  logic        vf_done;
  logic [61:0] region_dec;
  logic [31:0] wacc_sh;
  logic [3:0]  need;

  logic                 nv, tv, err;
  qtp_pkg::qtp_result_t nres, tres;

  always_comb begin
    if (vleft_q == 3'd0) begin
      vf_acc  = {56'd0, data_byte_i[5:0]};
      vf_left = 3'((4'd1 << data_byte_i[7:6]) - 4'd1);
    end else begin
      vf_acc  = {vacc_q[53:0], data_byte_i};
      vf_left = vleft_q - 3'd1;
    end
    vf_done    = (vf_left == 3'd0);
    region_dec = region_q - 62'd1;
    wacc_sh    = {wacc_q[23:0], data_byte_i};
    need       = 4'd1 << data_byte_i[7:6];
  end

  // Step: next state and the normal result of this byte
  always_comb begin
    phase_d  = phase_q;
    vacc_d   = vacc_q;
    vleft_d  = vleft_q;
    cur_d    = cur_q;
    region_d = region_q;
    wacc_d   = wacc_q;
    wbytes_d = wbytes_q;
    failed_d = failed_q;
    err      = 1'b0;
    nv       = 1'b0;
    nres     = '0;

    case (phase_q)
      PH_TYPE: begin
        vacc_d  = vf_acc;
        vleft_d = vf_left;
        if (vf_done) begin
          cur_d   = (vf_acc <= {57'd0, qtp_pkg::PCODE_VER}) ? vf_acc[4:0]
                                                             : qtp_pkg::PCODE_UNK;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        vacc_d  = vf_acc;
        vleft_d = vf_left;
        if (vf_done) begin
          if (cur_q == qtp_pkg::PCODE_UNK) begin
            if (vf_acc == 62'd0) begin
              nv      = 1'b1;
              nres    = make_res(qtp_pkg::KIND_SKIP, qtp_pkg::PCODE_UNK, 62'd0, 1'b1);
              phase_d = PH_TYPE;
            end else begin
              region_d = vf_acc;
              phase_d  = PH_PAD;
            end
          end else if (cur_q == qtp_pkg::PCODE_VER) begin
            if ((vf_acc < 62'(qtp_pkg::WORD_BYTES)) || (vf_acc[1:0] != 2'd0)) begin
              err = 1'b1;
            end else begin
              region_d = vf_acc;
              wacc_d   = '0;
              wbytes_d = '0;
              phase_d  = PH_VERC;
            end
          end else if (cur_q == qtp_pkg::PCODE_FLAG) begin
            if (vf_acc == 62'd0) begin
              nv      = 1'b1;
              nres    = make_res(qtp_pkg::KIND_FLAG, qtp_pkg::PCODE_FLAG, 62'd1, 1'b1);
              phase_d = PH_TYPE;
            end else begin
              phase_d = PH_FLAGV;
            end
          end else if (is_string(cur_q)) begin
            if (vf_acc == 62'd0) begin
              nv      = 1'b1;
              nres    = make_res(qtp_pkg::KIND_EMPTY, cur_q, 62'd0, 1'b1);
              phase_d = PH_TYPE;
            end else begin
              region_d = vf_acc;
              phase_d  = PH_STR;
            end
          end else begin
            if (vf_acc == 62'd0) begin
              err = 1'b1;
            end else begin
              region_d = vf_acc;
              phase_d  = PH_INTV;
            end
          end
        end
      end
      PH_INTV: begin
        if ((vleft_q == 3'd0) && (region_q < {58'd0, need})) begin
          err = 1'b1;
        end else begin
          region_d = region_dec;
          vacc_d   = vf_acc;
          vleft_d  = vf_left;
          if (vf_done) begin
            nv      = 1'b1;
            nres    = make_res(qtp_pkg::KIND_INT, cur_q, vf_acc, 1'b1);
            phase_d = (region_dec != 62'd0) ? PH_PAD : PH_TYPE;
          end
        end
      end
      PH_PAD: begin
        region_d = region_dec;
        if (region_dec == 62'd0) begin
          if (cur_q == qtp_pkg::PCODE_UNK) begin
            nv   = 1'b1;
            nres = make_res(qtp_pkg::KIND_SKIP, qtp_pkg::PCODE_UNK, 62'd0, 1'b1);
          end
          phase_d = PH_TYPE;
        end
      end
      PH_STR: begin
        region_d = region_dec;
        nv       = 1'b1;
        nres     = make_res(qtp_pkg::KIND_STRB, cur_q, {54'd0, data_byte_i},
                            region_dec == 62'd0);
        if (region_dec == 62'd0) begin
          phase_d = PH_TYPE;
        end
      end
      PH_FLAGV: begin
        vacc_d  = vf_acc;
        vleft_d = vf_left;
        if (vf_done) begin
          nv      = 1'b1;
          nres    = make_res(qtp_pkg::KIND_FLAG, qtp_pkg::PCODE_FLAG,
                             {61'd0, vf_acc != 62'd0}, 1'b1);
          phase_d = PH_TYPE;
        end
      end
      PH_VERC, PH_VERA: begin
        region_d = region_dec;
        wacc_d   = wacc_sh;
        if (wbytes_q == WordLast) begin
          nv       = 1'b1;
          nres     = make_res((phase_q == PH_VERC) ? qtp_pkg::KIND_CHOSEN
                                                   : qtp_pkg::KIND_AVAIL,
                              qtp_pkg::PCODE_VER, {30'd0, wacc_sh},
                              region_dec == 62'd0);
          wbytes_d = '0;
          wacc_d   = '0;
          phase_d  = (region_dec != 62'd0) ? PH_VERA : PH_TYPE;
        end else begin
          wbytes_d = wbytes_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_TYPE;
      end
    endcase

    // Terminal result: error, or block end
    tv   = err || final_byte_i;
    tres = make_res((!err && (phase_d == PH_TYPE) && (vleft_d == 3'd0))
                      ? qtp_pkg::KIND_DONE : qtp_pkg::KIND_ERR,
                    qtp_pkg::PCODE_NONE, 62'd0, 1'b0);
    tres.last_of_run = 1'b1;
    nres.last_of_run = !tv;
    if (err && !final_byte_i) begin
      failed_d = 1'b1;
    end

    // Drop everything while failed
    if (failed_q) begin
      nv = 1'b0;
      tv = 1'b0;
    end
  end

  // Pack results in order into the push bundle
  always_comb begin
    push_o = '0;
    if (fire_i) begin
      if (nv) begin
        push_o.v0 = 1'b1;
        push_o.r0 = nres;
        push_o.v1 = tv;
        push_o.r1 = tres;
      end else begin
        push_o.v0 = tv;
        push_o.r0 = tres;
      end
    end
  end

  // Advance state; final byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      vacc_q   <= '0;
      vleft_q  <= '0;
      cur_q    <= '0;
      region_q <= '0;
      wacc_q   <= '0;
      wbytes_q <= '0;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      if (final_byte_i) begin
        phase_q  <= PH_TYPE;
        vacc_q   <= '0;
        vleft_q  <= '0;
        cur_q    <= '0;
        region_q <= '0;
        wacc_q   <= '0;
        wbytes_q <= '0;
        failed_q <= 1'b0;
      end else if (!failed_q) begin
        phase_q  <= phase_d;
        vacc_q   <= vacc_d;
        vleft_q  <= vleft_d;
        cur_q    <= cur_d;
        region_q <= region_d;
        wacc_q   <= wacc_d;
        wbytes_q <= wbytes_d;
        failed_q <= failed_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_second_is_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> (push_o.v0 && ((push_o.r1.kind == qtp_pkg::KIND_DONE) ||
                                 (push_o.r1.kind == qtp_pkg::KIND_ERR))))
    else $error("second result of a byte is not a terminal result");
  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && fire_i) |-> !push_o.v0)
    else $error("result pushed while in failed state");
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !(fire_i && final_byte_i)) |=> failed_q)
    else $error("failed state cleared before the final byte");
`endif

endmodule

`default_nettype wire

@@ rtl/core/qtp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// qtp_result_fifo
// Small result queue: takes up to two results per cycle in order while it
// reports room, and presents one result per transaction on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qtp_result_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire qtp_pkg::qtp_push_t   push_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output qtp_pkg::qtp_result_t      head_o
);

  localparam int unsigned Depth = qtp_pkg::RES_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  qtp_pkg::qtp_result_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr1;
  logic [1:0]      n_wr;
  logic            pop;

  assign room_o      = (count_q <= CntW'(Depth - 2));
  assign out_valid_o = (count_q != '0);
  assign head_o      = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr1     = wr_ptr_q + PtrW'(1);
  assign n_wr        = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign count_d     = count_q + CntW'(n_wr) - CntW'(pop);

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      entry_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      entry_q[wr_ptr1] <= push_i.r1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_wr);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> (count_q <= CntW'(Depth - 2)))
    else $error("result pushed without room in queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count out of range");
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(head_o)))
    else $error("stalled result changed or dropped");
`endif

endmodule

`default_nettype wire

@@ rtl/core/quic_transport_param_parser_top.sv @@
// ----------------------------------------------------------------------------
// quic_transport_param_parser_top
// Transport parameter block parser: walks type/length/value entries one
// byte at a time and emits one result per output transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  input   | in        | in_valid_i/in_stall_o   | data_byte_i, final_byte_i
//  output  | out       | out_valid_o/out_stall_i | kind_o, param_code_o, value_o,
//          |           |                         | last_in_param_o, last_of_run_o
//
//  One byte per cycle while the queue has room; a byte is parsed in the cycle
//  after it is registered unless the input stalls. A byte giving two results
//  takes an extra output transaction; the four-entry result queue sets when
//  the input stalls (it needs room for two results).
//  Reset clears parse state and the queue; no clearing pass is needed.
//  Stall on the output holds the head result; stall on the input is driven
//  from registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module quic_transport_param_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       kind_o,
  output logic [4:0]       param_code_o,
  output logic [61:0]      value_o,
  output logic             last_in_param_o,
  output logic             last_of_run_o
);

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 final_q;
  logic                 room;
  logic                 fire;
  logic                 accept;
  qtp_pkg::qtp_push_t   push;
  qtp_pkg::qtp_result_t head;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register: load on transaction, drop once parsed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= data_byte_i;
      final_q <= final_byte_i;
    end
  end

  qtp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (byte_q),
    .final_byte_i (final_q),
    .push_o       (push)
  );

  qtp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o          = head.kind;
  assign param_code_o    = head.param_code;
  assign value_o         = head.value;
  assign last_in_param_o = head.last_in_param;
  assign last_of_run_o   = head.last_of_run;

endmodule

`default_nettype wire

@@ tb/quic_transport_param_parser_top_tb.sv @@
// ----------------------------------------------------------------------------
// quic_transport_param_parser_top_tb
// Self-checking bench for the transport parameter block parser. Blocks of
// type/length/value entries are fed one byte per input transaction. A
// cycle-free parser written here predicts the results of every accepted
// byte, and each output transaction is checked field by field against the
// oldest prediction. Well-formed, truncated and malformed blocks are run
// under three idle mixes on the two channels.
// ----------------------------------------------------------------------------
module quic_transport_param_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PS_TYPE, PS_LEN, PS_INTV, PS_PAD, PS_STR, PS_FLAGV, PS_VERC, PS_VERA
  } parse_state_e;

  localparam logic [61:0] VARINT_MAX = 62'h3FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data = 8'h00;
  logic        in_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_kind;
  logic [4:0]  out_code;
  logic [61:0] out_value;
  logic        out_last_param;
  logic        out_last_run;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_parsed = 0;
  int unsigned blocks_sent = 0;

  // Parser state mirrored by the predictor
  parse_state_e ps_state;
  logic [61:0]  ps_acc;
  logic [2:0]   ps_left;
  logic [4:0]   ps_code;
  logic [61:0]  ps_region;
  logic [31:0]  ps_word;
  logic [1:0]   ps_wbytes;
  bit           ps_failed;

  qtp_pkg::qtp_result_t run_buf [2];
  int                   run_n;
  qtp_pkg::qtp_result_t pending_results [$];
  logic [7:0]           blk_q [$];

  quic_transport_param_parser_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (in_data),
    .final_byte_i    (in_final),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (out_kind),
    .param_code_o    (out_code),
    .value_o         (out_value),
    .last_in_param_o (out_last_param),
    .last_of_run_o   (out_last_run)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAIL quic_transport_param_parser_top");
    $finish;
  end

  // Receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_parser();
    ps_state  = PS_TYPE;
    ps_acc    = '0;
    ps_left   = '0;
    ps_code   = '0;
    ps_region = '0;
    ps_word   = '0;
    ps_wbytes = '0;
    ps_failed = 1'b0;
  endtask

  task automatic add_result(input logic [3:0] kind, input logic [4:0] code,
                            input logic [61:0] val, input logic lastp);
    qtp_pkg::qtp_result_t r;
    if (run_n < 2) begin
      r.kind          = kind;
      r.param_code    = code;
      r.value         = val;
      r.last_in_param = lastp;
      r.last_of_run   = 1'b0;
      run_buf[run_n]  = r;
      run_n++;
    end
  endtask

  task automatic feed_varint(input logic [7:0] b, output bit complete);
    if (ps_left == 3'd0) begin
      ps_acc = {56'd0, b[5:0]};
      case (b[7:6])
        2'd0:    ps_left = 3'd0;
        2'd1:    ps_left = 3'd1;
        2'd2:    ps_left = 3'd3;
        default: ps_left = 3'd7;
      endcase
    end else begin
      ps_acc  = {ps_acc[53:0], b};
      ps_left = ps_left - 3'd1;
    end
    complete = (ps_left == 3'd0);
  endtask

  function automatic bit is_string_param(input logic [4:0] code);
    return code == qtp_pkg::PCODE_ORIG_DCID || code == qtp_pkg::PCODE_RESET_TOKEN ||
           code == qtp_pkg::PCODE_PREF_ADDR || code == qtp_pkg::PCODE_INIT_SCID ||
           code == qtp_pkg::PCODE_RETRY_SCID;
  endfunction

  // Act on a completed length varint
  task automatic take_length(output bit err);
    logic [61:0] len;
    len = ps_acc;
    err = 1'b0;
    if (ps_code == qtp_pkg::PCODE_UNK) begin
      if (len == 0) begin
        add_result(qtp_pkg::KIND_SKIP, qtp_pkg::PCODE_UNK, '0, 1'b1);
        ps_state = PS_TYPE;
      end else begin
        ps_region = len;
        ps_state  = PS_PAD;
      end
    end else if (ps_code == qtp_pkg::PCODE_VER) begin
      if (len < 62'(qtp_pkg::WORD_BYTES) || len[1:0] != 2'd0) begin
        err = 1'b1;
      end else begin
        ps_region = len;
        ps_word   = '0;
        ps_wbytes = '0;
        ps_state  = PS_VERC;
      end
    end else if (ps_code == qtp_pkg::PCODE_FLAG) begin
      if (len == 0) begin
        add_result(qtp_pkg::KIND_FLAG, qtp_pkg::PCODE_FLAG, 62'd1, 1'b1);
        ps_state = PS_TYPE;
      end else begin
        ps_state = PS_FLAGV;
      end
    end else if (is_string_param(ps_code)) begin
      if (len == 0) begin
        add_result(qtp_pkg::KIND_EMPTY, ps_code, '0, 1'b1);
        ps_state = PS_TYPE;
      end else begin
        ps_region = len;
        ps_state  = PS_STR;
      end
    end else if (len == 0) begin
      err = 1'b1;
    end else begin
      ps_region = len;
      ps_state  = PS_INTV;
    end
  endtask

  // Predict the results of one accepted byte and queue them
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    bit complete;
    bit err;
    run_n = 0;
    err   = 1'b0;
    // Drop everything after an error until the final byte
    if (ps_failed) begin
      if (fin) clear_parser();
      return;
    end
    bytes_parsed++;
    case (ps_state)
      PS_TYPE: begin
        feed_varint(b, complete);
        if (complete) begin
          ps_code  = (ps_acc <= {57'd0, qtp_pkg::PCODE_VER}) ? ps_acc[4:0]
                                                             : qtp_pkg::PCODE_UNK;
          ps_state = PS_LEN;
        end
      end
      PS_LEN: begin
        feed_varint(b, complete);
        if (complete) take_length(err);
      end
      PS_INTV: begin
        if (ps_left == 3'd0 && (62'd1 << b[7:6]) > ps_region) begin
          err = 1'b1;
        end else begin
          ps_region = ps_region - 62'd1;
          feed_varint(b, complete);
          if (complete) begin
            add_result(qtp_pkg::KIND_INT, ps_code, ps_acc, 1'b1);
            ps_state = (ps_region != 0) ? PS_PAD : PS_TYPE;
          end
        end
      end
      PS_PAD: begin
        ps_region = ps_region - 62'd1;
        if (ps_region == 0) begin
          if (ps_code == qtp_pkg::PCODE_UNK)
            add_result(qtp_pkg::KIND_SKIP, qtp_pkg::PCODE_UNK, '0, 1'b1);
          ps_state = PS_TYPE;
        end
      end
      PS_STR: begin
        ps_region = ps_region - 62'd1;
        add_result(qtp_pkg::KIND_STRB, ps_code, {54'd0, b}, ps_region == 0);
        if (ps_region == 0) ps_state = PS_TYPE;
      end
      PS_FLAGV: begin
        feed_varint(b, complete);
        if (complete) begin
          add_result(qtp_pkg::KIND_FLAG, qtp_pkg::PCODE_FLAG, {61'd0, ps_acc != 0}, 1'b1);
          ps_state = PS_TYPE;
        end
      end
      default: begin
        ps_region = ps_region - 62'd1;
        ps_word   = {ps_word[23:0], b};
        if (ps_wbytes == 2'd3) begin
          add_result((ps_state == PS_VERC) ? qtp_pkg::KIND_CHOSEN : qtp_pkg::KIND_AVAIL,
                     qtp_pkg::PCODE_VER, {30'd0, ps_word}, ps_region == 0);
          ps_wbytes = '0;
          ps_word   = '0;
          ps_state  = (ps_region != 0) ? PS_VERA : PS_TYPE;
        end else begin
          ps_wbytes = ps_wbytes + 2'd1;
        end
      end
    endcase

    // Error and block end
    if (err) begin
      add_result(qtp_pkg::KIND_ERR, qtp_pkg::PCODE_NONE, '0, 1'b0);
      if (fin) clear_parser();
      else ps_failed = 1'b1;
    end else if (fin) begin
      if (ps_state == PS_TYPE && ps_left == 3'd0)
        add_result(qtp_pkg::KIND_DONE, qtp_pkg::PCODE_NONE, '0, 1'b0);
      else add_result(qtp_pkg::KIND_ERR, qtp_pkg::PCODE_NONE, '0, 1'b0);
      clear_parser();
    end

    if (run_n > 0) run_buf[run_n-1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++)
      pending_results.insert(pending_results.size(), run_buf[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    qtp_pkg::qtp_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d code=%0d value=%0h",
                                  out_kind, out_code, out_value));
      end else begin
        e = pending_results.pop_front();
        if (out_kind !== e.kind)
          report_mismatch($sformatf("result %0d kind got %0d exp %0d",
                                    results_checked, out_kind, e.kind));
        if (out_code !== e.param_code)
          report_mismatch($sformatf("result %0d param_code got %0d exp %0d",
                                    results_checked, out_code, e.param_code));
        if (out_value !== e.value)
          report_mismatch($sformatf("result %0d value got %0h exp %0h",
                                    results_checked, out_value, e.value));
        if (out_last_param !== e.last_in_param)
          report_mismatch($sformatf("result %0d last_in_param got %0b exp %0b",
                                    results_checked, out_last_param, e.last_in_param));
        if (out_last_run !== e.last_of_run)
          report_mismatch($sformatf("result %0d last_of_run got %0b exp %0b",
                                    results_checked, out_last_run, e.last_of_run));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Send one byte; valid stays high into the next call unless it idles
  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_final <= fin;
    do @(posedge clk); while (in_stall);
    parse_byte(b, fin);
  endtask

  task automatic send_block();
    for (int i = 0; i < blk_q.size(); i++) send_byte(blk_q[i], i == blk_q.size() - 1);
    blk_q.delete();
    blocks_sent++;
  endtask

  // Hold the input until every predicted result has come out
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Block builders
  // ---------------------------------------------------------------------------
  function automatic int min_code(input logic [61:0] v);
    if (v < 62'd64) return 0;
    if (v < 62'd16384) return 1;
    if (v < 62'd1073741824) return 2;
    return 3;
  endfunction

  // Minimal size most of the time, otherwise a random size that may be wider
  function automatic int pick_code(input logic [61:0] v);
    int w;
    w = min_code(v);
    if (w < 3 && $urandom_range(3) == 0) w = $urandom_range(3, w);
    return w;
  endfunction

  task automatic put_varint(input logic [61:0] v, input int w);
    logic [63:0] vv;
    logic [7:0]  bt;
    int          nb;
    vv = {2'b00, v};
    nb = 1 << w;
    for (int i = nb - 1; i >= 0; i--) begin
      bt = vv[8*i +: 8];
      if (i == nb - 1) bt[7:6] = w[1:0];
      blk_q.insert(blk_q.size(), bt);
    end
  endtask

  task automatic put_varint_any(input logic [61:0] v);
    put_varint(v, pick_code(v));
  endtask

  task automatic put_noise(input int n);
    repeat (n) blk_q.insert(blk_q.size(), 8'($urandom));
  endtask

  function automatic logic [61:0] rand_varint_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return '0;
      1:       return VARINT_MAX;
      2:       return {56'd0, r[5:0]};
      3:       return {48'd0, r[13:0]};
      4:       return {32'd0, r[29:0]};
      default: return r[61:0];
    endcase
  endfunction

  function automatic int rand_int_type();
    int t;
    t = $urandom_range(10);
    if (t == 0) return 1;
    if (t == 10) return 14;
    return t + 2;
  endfunction

  function automatic int rand_str_type();
    case ($urandom_range(4))
      0:       return int'(qtp_pkg::PCODE_ORIG_DCID);
      1:       return int'(qtp_pkg::PCODE_RESET_TOKEN);
      2:       return int'(qtp_pkg::PCODE_PREF_ADDR);
      3:       return int'(qtp_pkg::PCODE_INIT_SCID);
      default: return int'(qtp_pkg::PCODE_RETRY_SCID);
    endcase
  endfunction

  task automatic add_entry();
    logic [61:0] v;
    int          w;
    int          n;
    int          pad;
    case ($urandom_range(19))
      // integer parameter, sometimes padded
      0, 1, 2, 3, 4, 5: begin
        v   = rand_varint_value();
        w   = pick_code(v);
        pad = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
        put_varint_any(62'(rand_int_type()));
        put_varint_any(62'((1 << w) + pad));
        put_varint(v, w);
        put_noise(pad);
      end
      // byte string, possibly empty
      6, 7, 8, 9: begin
        n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        put_varint_any(62'(rand_str_type()));
        put_varint_any(62'(n));
        put_noise(n);
      end
      // flag: empty is true, otherwise the next varint decides
      10, 11, 12: begin
        n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 5);
        put_varint_any({57'd0, qtp_pkg::PCODE_FLAG});
        put_varint_any(62'(n));
        if (n != 0) put_varint_any(($urandom_range(1) == 0) ? '0 : rand_varint_value());
      end
      // version information: chosen word, sometimes plus available words
      13, 14, 15: begin
        n = 4 * $urandom_range(1, 3);
        put_varint_any({57'd0, qtp_pkg::PCODE_VER});
        put_varint_any(62'(n));
        put_noise(n);
      end
      // unknown type, skipped
      default: begin
        v = rand_varint_value();
        if (v < 62'd18) v = v + 62'd18;
        n = $urandom_range(5);
        put_varint_any(v);
        put_varint_any(62'(n));
        put_noise(n);
      end
    endcase
  endtask

  task automatic build_wellformed(input int max_entries);
    repeat ($urandom_range(1, max_entries)) add_entry();
  endtask

  task automatic build_malformed();
    int          w;
    int          l;
    int          keep;
    logic [7:0]  bt;
    logic [61:0] v;
    case ($urandom_range(5))
      // truncated at a random point
      0: begin
        build_wellformed(3);
        if (blk_q.size() > 1) begin
          keep = $urandom_range(1, blk_q.size() - 1);
          while (blk_q.size() > keep) void'(blk_q.pop_back());
        end
      end
      // zero-length integer
      1: begin
        repeat ($urandom_range(2)) add_entry();
        put_varint_any(62'(rand_int_type()));
        put_varint_any('0);
        put_noise($urandom_range(4));
      end
      // version length not a positive multiple of four
      2: begin
        repeat ($urandom_range(2)) add_entry();
        l = $urandom_range(15);
        if (l % 4 == 0) l = 0;
        put_varint_any({57'd0, qtp_pkg::PCODE_VER});
        put_varint_any(62'(l));
        put_noise($urandom_range(4));
      end
      // inner varint longer than the integer length
      3: begin
        repeat ($urandom_range(2)) add_entry();
        w = $urandom_range(1, 3);
        l = $urandom_range(1, (1 << w) - 1);
        put_varint_any(62'(rand_int_type()));
        put_varint_any(62'(l));
        bt = 8'($urandom);
        bt[7:6] = w[1:0];
        blk_q.insert(blk_q.size(), bt);
        put_noise($urandom_range(4));
      end
      // raw noise
      4: put_noise($urandom_range(1, 8));
      // string with a length of at least eight, cut short
      default: begin
        v = rand_varint_value();
        if (v < 62'd8) v = 62'd300;
        put_varint_any(62'(rand_str_type()));
        put_varint_any(v);
        put_noise($urandom_range(5));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // empty flag, then block end
    blk_q = '{8'h0C, 8'h00};
    send_block();
    // zero-length integer on the final byte
    blk_q = '{8'h01, 8'h00};
    send_block();
    // bad version length, later bytes dropped until the final byte
    blk_q = '{8'h11, 8'h03, 8'hAA, 8'hBB};
    send_block();
    // inner varint wider than the length
    blk_q = '{8'h01, 8'h01, 8'h40};
    send_block();
    // empty string, one-byte string, unknown type with zero length
    blk_q = '{8'h00, 8'h00, 8'h02, 8'h01, 8'hFF, 8'h40, 8'h20, 8'h00};
    send_block();
    // chosen version only
    blk_q = '{8'h11, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_block();
    wait_results_drained();
  endtask

  task automatic test_wellformed(input int unsigned target);
    int unsigned start;
    start = bytes_parsed;
    while (bytes_parsed - start < target) begin
      build_wellformed(4);
      send_block();
    end
    wait_results_drained();
  endtask

  task automatic test_malformed(input int unsigned target);
    int unsigned start;
    start = bytes_parsed;
    while (bytes_parsed - start < target) begin
      build_malformed();
      send_block();
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles rarely, receiver often
    send_idle_pct = 7;
    recv_idle_pct = 57;
    test_directed();
    test_wellformed(400);
    test_malformed(170);

    // sender idles often, receiver rarely
    send_idle_pct = 57;
    recv_idle_pct = 7;
    test_wellformed(400);
    test_malformed(170);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_wellformed(400);
    test_malformed(170);

    // let late or stray results show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d blocks, %0d parsed bytes, %0d results checked, %0d mismatches",
             blocks_sent, bytes_parsed, results_checked, err_cnt);
    $display("Covered well-formed, truncated and malformed blocks under three idle mixes");
    if (err_cnt == 0) begin
      $display("PASS quic_transport_param_parser_top");
    end else begin
      $display("FAIL quic_transport_param_parser_top");
    end
    $finish;
  end

endmodule
